@@ rtl/tea_pkg.sv @@
// Shared types, constants and round functions for the TEA block encryptor.
`default_nettype none
package tea_pkg;

  localparam int unsigned CfgIndexWidth = 8;

  localparam logic [31:0] TEA_DELTA = 32'h9e37_79b9;

  // Configuration register indexes.
  localparam logic [CfgIndexWidth-1:0] CFG_KEY_WORD0 = 8'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_KEY_WORD1 = 8'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_KEY_WORD2 = 8'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_KEY_WORD3 = 8'd3;

  // Payload and valid bit carried by one pipeline stage.
  typedef struct packed {
    logic        valid;
    logic [31:0] left;
    logic [31:0] right;
  } tea_stage_t;

  // Running sum seen by round r (counting from zero): delta times (r + 1), modulo 2^32.
  function automatic logic [31:0] round_sum(input int unsigned r);
    logic [63:0] prod;
    prod = 64'(TEA_DELTA) * 64'(r + 1);
    return prod[31:0];
  endfunction

  // Shift-add-xor mixing of one half against the round sum and two key words.
  function automatic logic [31:0] tea_mix(input logic [31:0] half,
                                          input logic [31:0] sum,
                                          input logic [31:0] ka,
                                          input logic [31:0] kb);
    return ((half << 4) + ka) ^ (half + sum) ^ ((half >> 5) + kb);
  endfunction

endpackage
`default_nettype wire

@@ rtl/tea_half_round.sv @@
// One pipeline stage performing a single half update of a TEA cycle.
`default_nettype none
module tea_half_round #(
  parameter bit          UPDATE_RIGHT = 1'b0,
  parameter logic [31:0] ROUND_SUM    = 32'h9e37_79b9
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      en,
  input  wire tea_pkg::tea_stage_t stage_in,
  input  wire               [31:0] key_a,
  input  wire               [31:0] key_b,
  output tea_pkg::tea_stage_t      stage_out
);

  logic                valid_r;
  logic [31:0]         left_r;
  logic [31:0]         right_r;
  tea_pkg::tea_stage_t stage_nxt;

  always_comb begin
    stage_nxt = stage_in;
    if (UPDATE_RIGHT) begin
      stage_nxt.right = stage_in.right +
                        tea_pkg::tea_mix(stage_in.left, ROUND_SUM, key_a, key_b);
    end else begin
      stage_nxt.left = stage_in.left +
                       tea_pkg::tea_mix(stage_in.right, ROUND_SUM, key_a, key_b);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= stage_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      left_r  <= stage_nxt.left;
      right_r <= stage_nxt.right;
    end
  end

  assign stage_out = '{valid: valid_r, left: left_r, right: right_r};

endmodule
`default_nettype wire

@@ rtl/tea_block_encrypt.sv @@
// Top level of the pipelined TEA block encryptor with key registers and output register.
`default_nettype none
// Usage
// The input channel (in_valid, in_ready, in_plain_left, in_plain_right) takes one
// 64-bit plaintext block per transaction; the output channel (out_valid, out_ready,
// out_cipher_left, out_cipher_right) returns one ciphertext block per transaction,
// in the order the blocks were accepted.
// The 128-bit key lives in four 32-bit registers written over the cfg_ channel
// (index 0 to 3; writes to any other index are ignored). cfg_ready is always high.
// Change the key only while no block is in flight.
// Every TEA cycle is split into two pipeline stages, one per half update, so the
// pipeline has 2 * ROUND_COUNT stages followed by the output register. A block
// accepted on the input passes through every pipeline stage in order and then
// through the output register before it is presented on the output.
// Throughput is one block per cycle: a new block enters at each edge with in_ready high.
// When the receiver stalls, the result waits in the output register and the
// pipeline keeps accepting blocks until its last stage also holds one; only then
// does in_ready fall, and the whole pipeline freezes without dropping or
// repeating any block.
// Reset (rst_n low at a clock edge) empties the pipeline and clears the key to zero.
module tea_block_encrypt #(
  parameter int unsigned ROUND_COUNT = 32
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  [31:0]                          in_plain_left,
  input  wire  [31:0]                          in_plain_right,
  output logic                                 out_valid,
  input  wire                                  out_ready,
  output logic [31:0]                          out_cipher_left,
  output logic [31:0]                          out_cipher_right,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [tea_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  wire  [31:0]                          cfg_data
);

  localparam int unsigned StageCount = 2 * ROUND_COUNT;

  // Key registers.
  logic [31:0] key0_r;
  logic [31:0] key1_r;
  logic [31:0] key2_r;
  logic [31:0] key3_r;

  // Output register.
  logic        out_valid_r;
  logic [31:0] out_left_r;
  logic [31:0] out_right_r;

  // Stage 0 is the incoming transaction; stage StageCount is the last pipeline register.
  tea_pkg::tea_stage_t pipe [StageCount+1];
  tea_pkg::tea_stage_t last_stage;

  logic pipe_en;

  // The configuration port never back-pressures.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= '0;
      key1_r <= '0;
      key2_r <= '0;
      key3_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tea_pkg::CFG_KEY_WORD0: key0_r <= cfg_data;
        tea_pkg::CFG_KEY_WORD1: key1_r <= cfg_data;
        tea_pkg::CFG_KEY_WORD2: key2_r <= cfg_data;
        tea_pkg::CFG_KEY_WORD3: key3_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pipe[0].valid = in_valid;
  assign pipe[0].left  = in_plain_left;
  assign pipe[0].right = in_plain_right;

  assign last_stage = pipe[StageCount];

  // The pipeline moves unless its last stage holds a block that cannot enter the
  // output register because the result there is still waiting.
  assign pipe_en  = !(last_stage.valid && out_valid_r && !out_ready);
  assign in_ready = pipe_en;

  // Even stages update the left half with key words 0 and 1; odd stages update
  // the right half with key words 2 and 3. Each round's sum is a constant.
  for (genvar g = 0; g < StageCount; g++) begin : g_stage
    tea_half_round #(
      .UPDATE_RIGHT((g % 2) == 1),
      .ROUND_SUM   (tea_pkg::round_sum(g / 2))
    ) u_half_round (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (pipe_en),
      .stage_in (pipe[g]),
      .key_a    (((g % 2) == 1) ? key2_r : key0_r),
      .key_b    (((g % 2) == 1) ? key3_r : key1_r),
      .stage_out(pipe[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready || !out_valid_r) begin
      out_valid_r <= last_stage.valid;
    end
  end

  always_ff @(posedge clk) begin
    if ((out_ready || !out_valid_r) && last_stage.valid) begin
      out_left_r  <= last_stage.left;
      out_right_r <= last_stage.right;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cipher_left  = out_left_r;
  assign out_cipher_right = out_right_r;

  // Input back-pressure only ever comes from a stalled, occupied output register.
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid_r && !out_ready && last_stage.valid))
    else $error("input stalled without a blocked result");

  // A block held in the last stage during a stall is not lost.
  a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
    (last_stage.valid && !pipe_en) |=> last_stage.valid)
    else $error("last pipeline stage dropped a block during a stall");

  // A block leaving the last stage while the output is free appears on the output.
  a_to_output: assert property (@(posedge clk) disable iff (!rst_n)
    (last_stage.valid && pipe_en) |=> out_valid_r)
    else $error("block left the pipeline without reaching the output register");

  // A write to key word 0 is visible on the next cycle.
  a_key0_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && cfg_index == tea_pkg::CFG_KEY_WORD0)
      |=> (key0_r == $past(cfg_data)))
    else $error("key word 0 write not taken");

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the pipelined TEA block encryptor.
`timescale 1ns / 100ps

module testbench;

  typedef logic [tea_pkg::CfgIndexWidth-1:0] cfg_index_t;

  localparam int unsigned RoundCount = 32;
  // The longest quiet stretch of a correct run is the long receiver hold-off
  // plus the pipeline depth, so this leaves a wide margin.
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned BlocksPerPhase = 225;
  // An index with every bit above the key range set; no register lives there.
  localparam cfg_index_t CfgIndexUnused = 8'hfc;
  localparam cfg_index_t KeyIndex [4] =
    '{tea_pkg::CFG_KEY_WORD0, tea_pkg::CFG_KEY_WORD1,
      tea_pkg::CFG_KEY_WORD2, tea_pkg::CFG_KEY_WORD3};

  typedef struct packed {
    logic [31:0] left;
    logic [31:0] right;
  } block_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_plain_left = '0;
  logic [31:0] in_plain_right = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_cipher_left;
  logic [31:0] out_cipher_right;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  cfg_index_t  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Plaintext blocks waiting to be offered, and ciphertexts owed by the block.
  block_t      pending_blocks[$];
  block_t      expected_ciphers[$];
  // Our own copy of the key, updated whenever a key write is accepted.
  logic [31:0] key_word_q [4] = '{default: '0};

  int unsigned blocks_sent = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned key_writes = 0;
  int unsigned unused_writes = 0;
  int unsigned key_settings = 1;
  int unsigned input_stall_cycles = 0;
  int unsigned long_holds = 0;
  int unsigned quiet_cycles = 0;

  tea_block_encrypt #(.ROUND_COUNT(RoundCount)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_plain_left    (in_plain_left),
    .in_plain_right   (in_plain_right),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cipher_left  (out_cipher_left),
    .out_cipher_right (out_cipher_right),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // TEA encryption of one block under the current key. The sum starts from
  // zero for every block, so blocks are independent of one another; the right
  // shift is logical and bits shifted out on the left are simply lost.
  function automatic block_t encipher_block(input logic [31:0] plain_left,
                                            input logic [31:0] plain_right);
    logic [31:0] left;
    logic [31:0] right;
    logic [31:0] sum;
    block_t      cipher;
    left = plain_left;
    right = plain_right;
    sum = '0;
    for (int unsigned rnd = 0; rnd < RoundCount; rnd++) begin
      sum = sum + tea_pkg::TEA_DELTA;
      left = left + (((right << 4) + key_word_q[0]) ^ (right + sum) ^
                     ((right >> 5) + key_word_q[1]));
      right = right + (((left << 4) + key_word_q[2]) ^ (left + sum) ^
                       ((left >> 5) + key_word_q[3]));
    end
    cipher.left = left;
    cipher.right = right;
    return cipher;
  endfunction

  // A random word that hits the all-zero and all-one extremes fairly often.
  function automatic logic [31:0] draw_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // A random index above the key range.
  function automatic cfg_index_t draw_unused_index();
    return cfg_index_t'($urandom_range(tea_pkg::CFG_KEY_WORD3 + 1, 255));
  endfunction

  // Sender. Each block is offered after a random gap, except during bursts in
  // which blocks follow back to back. Once valid is raised the payload is held
  // until the transaction completes.
  int unsigned tx_gap = 0;
  bit          tx_burst = 1'b0;

  always @(posedge clk) begin
    block_t blk;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_ciphers.push_back(encipher_block(in_plain_left, in_plain_right));
        blocks_sent++;
      end else if (in_valid) begin
        input_stall_cycles++;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_blocks.size() != 0) begin
          blk = pending_blocks.pop_front();
          in_plain_left <= blk.left;
          in_plain_right <= blk.right;
          in_valid <= 1'b1;
          if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
          tx_gap = tx_burst ? 0 : $urandom_range(0, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker. Every ciphertext is compared with the oldest
  // prediction. Twice in the run the receiver holds off for a long stretch
  // while the sender keeps going, so the pipeline fills and in_ready drops.
  int unsigned rx_gap = 0;
  int unsigned hold_left = 0;
  bit          rx_burst = 1'b0;

  always @(posedge clk) begin
    block_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_ciphers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected ciphertext left=%h right=%h with nothing outstanding",
                     out_cipher_left, out_cipher_right);
        end else begin
          want = expected_ciphers.pop_front();
          if (want.left !== out_cipher_left || want.right !== out_cipher_right) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: left expected %h got %h, right expected %h got %h",
                       results_seen, want.left, out_cipher_left,
                       want.right, out_cipher_right);
          end
        end
        if (results_seen == 350 || results_seen == 1200) begin
          hold_left = LongHoldCycles;
          long_holds++;
        end else begin
          if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
          rx_gap = rx_burst ? 0 : $urandom_range(0, 3);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: a stretch with no transaction on any channel means a hang.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no transaction for %0d cycles", quiet_cycles);
      $display("[tea_block_encrypt] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Key writes are driven with nonblocking assignments. Valid is left high so that
  // back-to-back writes never lower and raise it in the same step; the caller
  // drops it with close_key_writes once the batch is done.
  task automatic write_key_reg(input cfg_index_t idx,
                               input logic [31:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    key_writes++;
    if (idx <= tea_pkg::CFG_KEY_WORD3) key_word_q[idx[1:0]] = data;
    else unused_writes++;
  endtask

  task automatic close_key_writes();
    cfg_valid <= 1'b0;
    @(posedge clk);
    key_settings++;
  endtask

  // Waits until every queued block has been taken and every ciphertext has come
  // back, so the pipeline is empty and the key may be changed.
  task automatic wait_drained();
    while (pending_blocks.size() != 0 || in_valid || expected_ciphers.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_directed_blocks();
    block_t blk;
    blk = '{32'h0000_0000, 32'h0000_0000}; pending_blocks.push_back(blk);
    blk = '{32'hffff_ffff, 32'hffff_ffff}; pending_blocks.push_back(blk);
    blk = '{32'h0000_0000, 32'hffff_ffff}; pending_blocks.push_back(blk);
    blk = '{32'hffff_ffff, 32'h0000_0000}; pending_blocks.push_back(blk);
    // Top bit set in one half checks that the right shift brings in zeros.
    blk = '{32'h8000_0000, 32'h0000_0001}; pending_blocks.push_back(blk);
    blk = '{32'h0000_0001, 32'h8000_0000}; pending_blocks.push_back(blk);
    blk = '{32'haaaa_aaaa, 32'h5555_5555}; pending_blocks.push_back(blk);
    blk = '{32'h5555_5555, 32'haaaa_aaaa}; pending_blocks.push_back(blk);
    blk = '{32'h0123_4567, 32'h89ab_cdef}; pending_blocks.push_back(blk);
    blk = '{32'hf000_000f, 32'h0fff_fff0}; pending_blocks.push_back(blk);
  endtask

  initial begin
    block_t blk;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The key as it comes out of reset is all zeros.
    queue_directed_blocks();
    wait_drained();

    // All-ones key: the additions of key words carry all the way through.
    foreach (KeyIndex[i]) write_key_reg(KeyIndex[i], '1);
    close_key_writes();
    queue_directed_blocks();
    wait_drained();

    // Writes to indexes beyond the key must leave the key untouched.
    write_key_reg(CfgIndexUnused, 32'h1234_5678);
    write_key_reg(draw_unused_index(), $urandom());
    close_key_writes();
    repeat (30) begin
      blk = '{draw_word(), draw_word()};
      pending_blocks.push_back(blk);
    end
    wait_drained();

    // Random keys, each register rewritten most of the time, with the odd
    // stray write to an unused index mixed in.
    repeat (RandomPhases) begin
      foreach (KeyIndex[i])
        if ($urandom_range(0, 3) != 0) write_key_reg(KeyIndex[i], draw_word());
      if ($urandom_range(0, 2) == 0)
        write_key_reg(draw_unused_index(), $urandom());
      close_key_writes();
      repeat (BlocksPerPhase) begin
        blk = '{draw_word(), draw_word()};
        pending_blocks.push_back(blk);
      end
      wait_drained();
    end

    // Give any stray result time to surface before judging the run.
    repeat (2 * RoundCount + 8) @(posedge clk);
    mismatches += expected_ciphers.size();

    $display("encrypted %0d blocks under %0d key settings; %0d key writes, %0d to unused indexes",
             blocks_sent, key_settings, key_writes, unused_writes);
    $display("input held off for %0d cycles; %0d long receiver hold-offs; %0d failures",
             input_stall_cycles, long_holds, mismatches);
    if (mismatches == 0)
      $display("[tea_block_encrypt] OK");
    else
      $display("[tea_block_encrypt] ERROR");
    $finish;
  end

endmodule

@@ files.f @@
rtl/tea_pkg.sv
rtl/tea_half_round.sv
rtl/tea_block_encrypt.sv
sim/testbench.sv
